// ===== rtl/cfcm_pkg.sv =====
package cfcm_pkg;

  localparam int NumPeersDef     = 4;
  localparam int MaxVcsDef       = 8;
  localparam int CountBitsDef    = 16;
  localparam int LinkPeerDef     = 0;
  localparam int QueueDepth      = 2;

  localparam int OpW    = 4;
  localparam int PeerW  = 2;
  localparam int ChanW  = 3;
  localparam int FieldW = 16;
  localparam int VcCntW = 4;

  typedef enum logic [OpW-1:0] {
    OP_CHECK       = 4'd0,
    OP_CONSUME_SZ  = 4'd1,
    OP_CONSUME_CNT = 4'd2,
    OP_ADD         = 4'd3,
    OP_SET         = 4'd4,
    OP_DATA_RX     = 4'd5,
    OP_RET_POLL    = 4'd6,
    OP_CLEAR_OWED  = 4'd7,
    OP_INIT_PEER   = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    CFG_FLOW_EN  = 3'd0,
    CFG_POOL     = 3'd1,
    CFG_VC_COUNT = 3'd2,
    CFG_INIT_BUD = 3'd3,
    CFG_RET_BAT  = 3'd4,
    CFG_SIZE_EN  = 3'd5,
    CFG_MIN_CRED = 3'd6,
    CFG_BPC      = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic                flow_enable;
    logic                pool_mode;
    logic [VcCntW-1:0]   vc_count;
    logic [FieldW-1:0]   initial_budget;
    logic [FieldW-1:0]   return_batch;
    logic                size_based_enable;
    logic [FieldW-1:0]   min_credit;
    logic [FieldW-1:0]   bytes_each_credit;
  } cfg_t;

  // classified command passed from front to back
  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [PeerW-1:0]  peer;
    logic [ChanW-1:0]  chan;
    logic [FieldW-1:0] needed;
    logic [FieldW-1:0] amount;
    logic [FieldW-1:0] per_vc;
  } cmd_t;

endpackage

// ===== rtl/cfcm_divider.sv =====
// Restoring 16/16 divider, one quotient bit per cycle.
module cfcm_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [cfcm_pkg::FieldW-1:0] dividend,
  input  logic [cfcm_pkg::FieldW-1:0] divisor,
  output logic                      done,
  output logic [cfcm_pkg::FieldW-1:0] quotient,
  output logic [cfcm_pkg::FieldW-1:0] remainder
);
  import cfcm_pkg::*;

  localparam int CntW = $clog2(FieldW + 1);

  logic [FieldW-1:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;
  logic [FieldW:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {r_r, q_r[FieldW-1]} - {1'b0, d_r};
    if (start && !busy_r) begin
      q_nxt    = dividend;
      r_nxt    = '0;
      d_nxt    = divisor;
      cnt_nxt  = CntW'(FieldW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[FieldW]) begin
        r_nxt = trial[FieldW-1:0];
        q_nxt = {q_r[FieldW-2:0], 1'b1};
      end else begin
        r_nxt = {r_r[FieldW-2:0], q_r[FieldW-1]};
        q_nxt = {q_r[FieldW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = r_r;
endmodule

// ===== rtl/cfcm_front.sv =====
// Front: accepts beats, works out needed credits / init split, queues commands.
module cfcm_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cfcm_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cfcm_pkg::OpW-1:0]    in_operation,
  input  logic [cfcm_pkg::PeerW-1:0]  in_peer,
  input  logic [cfcm_pkg::ChanW-1:0]  in_channel,
  input  logic [cfcm_pkg::FieldW-1:0] in_packet_bytes,
  input  logic [cfcm_pkg::FieldW-1:0] in_credit_amount,
  output logic                        q_valid,
  output cfcm_pkg::cmd_t              q_cmd,
  input  logic                        q_pop
);
  import cfcm_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_PUSH = 3'b100
  } fstate_t;

  fstate_t         state_r, state_nxt;
  cmd_t            cmd_r, cmd_nxt;
  logic [FieldW-1:0] bpc_r, bpc_nxt;
  logic            div_start, div_done;
  logic [FieldW-1:0] div_q, div_rem, div_a, div_b;
  logic [FieldW-1:0] ceil_q;
  logic            push;

  cmd_t            fifo_r [QueueDepth];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [PtrW:0]   cnt_r;
  logic            full;

  assign full     = (cnt_r == (PtrW+1)'(QueueDepth));
  assign in_stall = (state_r != S_IDLE);

  // operand select for the shared divider
  always_comb begin
    if (in_operation == OP_INIT_PEER) begin
      div_a = (in_credit_amount != '0) ? in_credit_amount : cfg.initial_budget;
      div_b = (cfg.vc_count != '0) ? FieldW'(cfg.vc_count) : FieldW'(1);
    end else begin
      div_a = in_packet_bytes;
      div_b = (cfg.bytes_each_credit != '0) ? cfg.bytes_each_credit : FieldW'(1);
    end
  end

  assign ceil_q = div_q + FieldW'(div_rem != '0);

  cfcm_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend(div_a), .divisor(div_b),
    .done(div_done),
    .quotient(div_q), .remainder(div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    bpc_nxt   = bpc_r;
    div_start = 1'b0;
    push      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt.op     = in_operation;
          cmd_nxt.peer   = in_peer;
          cmd_nxt.chan   = in_channel;
          cmd_nxt.amount = in_credit_amount;
          cmd_nxt.needed = cfg.min_credit;
          cmd_nxt.per_vc = '0;
          bpc_nxt        = div_a;
          if ((in_operation == OP_INIT_PEER) ||
              (cfg.size_based_enable && (in_operation == OP_CHECK ||
               in_operation == OP_CONSUME_SZ || in_operation == OP_DATA_RX))) begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_PUSH;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (cmd_r.op == OP_INIT_PEER) begin
            cmd_nxt.amount = bpc_r;
            cmd_nxt.per_vc = div_q;
          end else if (ceil_q > cmd_r.needed) begin
            cmd_nxt.needed = ceil_q;
          end
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!full) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // command queue
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    bpc_r <= bpc_nxt;
    if (push) fifo_r[wp_r] <= cmd_r;
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r    <= '0;
      rp_r    <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(q_pop);
    end
  end

  assign q_valid = (cnt_r != '0);
  assign q_cmd   = fifo_r[rp_r];
endmodule

// ===== rtl/cfcm_back.sv =====
// Back: applies a command to the credit tables, registers one result beat.
module cfcm_back #(
  parameter int NumPeers  = cfcm_pkg::NumPeersDef,
  parameter int MaxVcs    = cfcm_pkg::MaxVcsDef,
  parameter int CountBits = cfcm_pkg::CountBitsDef,
  parameter int LinkPeer  = cfcm_pkg::LinkPeerDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cfcm_pkg::cfg_t              cfg,
  input  logic                        q_valid,
  input  cfcm_pkg::cmd_t              q_cmd,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_ok,
  output logic [cfcm_pkg::FieldW-1:0] out_needed,
  output logic [cfcm_pkg::FieldW-1:0] out_balance,
  output logic                        out_send_credit,
  output logic [cfcm_pkg::FieldW-1:0] out_owed_count
);
  import cfcm_pkg::*;

  localparam int Depth = NumPeers * MaxVcs;
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int WideW = (CountBits > FieldW) ? CountBits + 1 : FieldW + 1;
  localparam logic [WideW-1:0] CMax = WideW'((64'd1 << CountBits) - 64'd1);

  logic [CountBits-1:0] tx_r   [Depth];
  logic [CountBits-1:0] owed_r [Depth];
  logic [CountBits-1:0] pool_r;

  logic            ov_r;
  logic            ok_r, send_r;
  logic [FieldW-1:0] need_r, bal_r, owe_r;
  logic            fire;
  logic            peer_ok, chan_ok, use_sh, valid, owed_ok;
  logic [IdxW-1:0] idx;
  logic [WideW-1:0] cur, ocur, amt, sum, osum, newv;
  logic            ok_c, send_c, wr_tx, wr_sh, wr_ow, clr, init;
  logic [WideW-1:0] owed_out;
  logic [31:0]     lim;
  logic            is_meas;

  assign fire  = q_valid && (!ov_r || !out_stall);
  assign q_pop = fire;

  function automatic logic [FieldW-1:0] sat16(input logic [WideW-1:0] v);
    sat16 = (v > WideW'(16'hFFFF)) ? 16'hFFFF : v[FieldW-1:0];
  endfunction

  always_comb begin
    peer_ok = (32'(q_cmd.peer) < NumPeers);
    chan_ok = (32'(q_cmd.chan) < MaxVcs);
    use_sh  = !cfg.pool_mode && (32'(q_cmd.peer) == LinkPeer);
    valid   = (peer_ok && chan_ok) || (use_sh && peer_ok);
    owed_ok = peer_ok && chan_ok;
    idx     = (peer_ok && chan_ok) ?
              IdxW'(32'(q_cmd.peer) * MaxVcs + 32'(q_cmd.chan)) : '0;
    cur     = use_sh ? WideW'(pool_r) : WideW'(tx_r[idx]);
    ocur    = WideW'(owed_r[idx]);
    amt     = WideW'(q_cmd.amount);
    sum     = cur + amt;
    osum    = ocur + WideW'(q_cmd.needed);
    lim     = (32'(cfg.vc_count) < MaxVcs) ? 32'(cfg.vc_count) : MaxVcs;
    ok_c = 1'b0; send_c = 1'b0; wr_tx = 1'b0; wr_ow = 1'b0;
    clr = 1'b0; init = 1'b0; newv = cur; is_meas = 1'b0;
    if (valid) begin
      priority case (q_cmd.op)
        OP_CHECK: begin
          is_meas = 1'b1;
          ok_c = cur >= WideW'(q_cmd.needed);
        end
        OP_CONSUME_SZ: begin
          is_meas = 1'b1;
          if (cur >= WideW'(q_cmd.needed)) begin
            ok_c = 1'b1; wr_tx = 1'b1; newv = cur - WideW'(q_cmd.needed);
          end
        end
        OP_CONSUME_CNT: begin
          if (cur >= amt) begin
            ok_c = 1'b1; wr_tx = 1'b1; newv = cur - amt;
          end
        end
        OP_ADD: begin
          ok_c = 1'b1; wr_tx = 1'b1; newv = (sum > CMax) ? CMax : sum;
        end
        OP_SET: begin
          ok_c = 1'b1; wr_tx = 1'b1; newv = (amt > CMax) ? CMax : amt;
        end
        OP_DATA_RX: begin
          is_meas = 1'b1;
          if (cfg.flow_enable && owed_ok) begin
            ok_c = 1'b1; wr_ow = 1'b1;
          end
        end
        OP_RET_POLL: begin
          send_c = owed_ok && cfg.flow_enable && (ocur >= WideW'(cfg.return_batch));
          ok_c   = send_c;
        end
        OP_CLEAR_OWED: begin
          if (owed_ok) begin
            clr = 1'b1; ok_c = 1'b1;
          end
        end
        OP_INIT_PEER: begin
          init = 1'b1; ok_c = 1'b1;
          // addressed channel reports its reloaded share, or the whole reloaded pool when shared
          if (use_sh) newv = (amt > CMax) ? CMax : amt;
          else if (32'(q_cmd.chan) < lim) newv = WideW'(q_cmd.per_vc);
        end
        default: ;
      endcase
    end
    wr_sh = use_sh && (wr_tx || init);
    if (!owed_ok) owed_out = '0;
    else if (wr_ow) owed_out = (osum > CMax) ? CMax : osum;
    else if (init && (32'(q_cmd.chan) < lim)) owed_out = '0;
    else owed_out = ocur;
  end

  // result registers load only on a fired command, hold while stalled
  always_ff @(posedge clk) begin
    if (fire) begin
      ok_r   <= ok_c;
      send_r <= send_c;
      need_r <= is_meas ? q_cmd.needed :
                (q_cmd.op == OP_CONSUME_CNT && valid) ? q_cmd.amount : '0;
      bal_r  <= valid ? sat16(newv) : '0;
      owe_r  <= sat16(owed_out);
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      pool_r <= '0;
      for (int i = 0; i < Depth; i++) begin
        tx_r[i]   <= '0;
        owed_r[i] <= '0;
      end
    end else begin
      if (fire) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      if (fire) begin
        if (wr_sh) pool_r <= newv[CountBits-1:0];
        else if (wr_tx) tx_r[idx] <= newv[CountBits-1:0];
        if (wr_ow) owed_r[idx] <= owed_out[CountBits-1:0];
        if (clr) owed_r[idx] <= '0;
        if (init) begin
          for (int v = 0; v < MaxVcs; v++) begin
            if (32'(v) < lim) begin
              if (!use_sh)
                tx_r[32'(q_cmd.peer) * MaxVcs + v] <= CountBits'(q_cmd.per_vc);
              owed_r[32'(q_cmd.peer) * MaxVcs + v] <= '0;
            end
          end
        end
      end
    end
  end

  assign out_valid       = ov_r;
  assign out_ok          = ok_r;
  assign out_needed      = need_r;
  assign out_balance     = bal_r;
  assign out_send_credit = send_r;
  assign out_owed_count  = owe_r;
endmodule

// ===== rtl/credit_flow_control_manager.sv =====
// Credit flow control manager: front classifies and divides, back applies.
// Path: the front registers the command (through the 16-step serial divider for
// size-based ops and init peer) and queues it; the back registers the result.
// The front stalls new beats until the current command is pushed to the queue.
// Reset (rst_n sync, low): registers to defaults, all credit/owed counters zero.
module credit_flow_control_manager #(
  parameter int NUM_PEERS       = cfcm_pkg::NumPeersDef,
  parameter int MAX_VCS         = cfcm_pkg::MaxVcsDef,
  parameter int COUNT_BITS      = cfcm_pkg::CountBitsDef,
  parameter int LINK_PEER_INDEX = cfcm_pkg::LinkPeerDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [cfcm_pkg::FieldW-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cfcm_pkg::OpW-1:0]    in_operation,
  input  logic [cfcm_pkg::PeerW-1:0]  in_peer,
  input  logic [cfcm_pkg::ChanW-1:0]  in_channel,
  input  logic [cfcm_pkg::FieldW-1:0] in_packet_bytes,
  input  logic [cfcm_pkg::FieldW-1:0] in_credit_amount,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_ok,
  output logic [cfcm_pkg::FieldW-1:0] out_needed,
  output logic [cfcm_pkg::FieldW-1:0] out_balance,
  output logic                        out_send_credit,
  output logic [cfcm_pkg::FieldW-1:0] out_owed_count
);
  import cfcm_pkg::*;

  cfg_t cfg_r;
  logic q_valid, q_pop;
  cmd_t q_cmd;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flow_enable       <= 1'b0;
      cfg_r.pool_mode         <= 1'b0;
      cfg_r.vc_count          <= VcCntW'(4);
      cfg_r.initial_budget    <= FieldW'(20);
      cfg_r.return_batch      <= FieldW'(1);
      cfg_r.size_based_enable <= 1'b1;
      cfg_r.min_credit        <= FieldW'(1);
      cfg_r.bytes_each_credit <= FieldW'(256);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FLOW_EN:  cfg_r.flow_enable       <= cfg_data[0];
        CFG_POOL:     cfg_r.pool_mode         <= cfg_data[0];
        CFG_VC_COUNT: cfg_r.vc_count          <= cfg_data[VcCntW-1:0];
        CFG_INIT_BUD: cfg_r.initial_budget    <= cfg_data;
        CFG_RET_BAT:  cfg_r.return_batch      <= cfg_data;
        CFG_SIZE_EN:  cfg_r.size_based_enable <= cfg_data[0];
        CFG_MIN_CRED: cfg_r.min_credit        <= cfg_data;
        CFG_BPC:      cfg_r.bytes_each_credit <= cfg_data;
        default: ;
      endcase
    end
  end

  cfcm_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_peer(in_peer), .in_channel(in_channel),
    .in_packet_bytes(in_packet_bytes), .in_credit_amount(in_credit_amount),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
  );

  cfcm_back #(
    .NumPeers(NUM_PEERS), .MaxVcs(MAX_VCS),
    .CountBits(COUNT_BITS), .LinkPeer(LINK_PEER_INDEX)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_ok(out_ok), .out_needed(out_needed), .out_balance(out_balance),
    .out_send_credit(out_send_credit), .out_owed_count(out_owed_count)
  );
endmodule

// ===== sim/credit_flow_control_manager_chk.sv =====
module credit_flow_control_manager_chk (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [cfcm_pkg::FieldW-1:0] cfg_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [cfcm_pkg::OpW-1:0]    in_operation,
  input  logic [cfcm_pkg::PeerW-1:0]  in_peer,
  input  logic [cfcm_pkg::ChanW-1:0]  in_channel,
  input  logic [cfcm_pkg::FieldW-1:0] in_packet_bytes,
  input  logic [cfcm_pkg::FieldW-1:0] in_credit_amount,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        out_ok,
  input  logic [cfcm_pkg::FieldW-1:0] out_needed,
  input  logic [cfcm_pkg::FieldW-1:0] out_balance,
  input  logic                        out_send_credit,
  input  logic [cfcm_pkg::FieldW-1:0] out_owed_count,
  output int                          fails,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import cfcm_pkg::*;

  localparam int Vcs = MaxVcsDef;
  localparam logic [FieldW-1:0] CountMax = '1;

  typedef struct packed {
    logic              ok;
    logic [FieldW-1:0] needed;
    logic [FieldW-1:0] balance;
    logic              send_credit;
    logic [FieldW-1:0] owed;
  } credit_result_t;

  // shadow of the block's registers and credit tables
  cfg_t              regs;
  logic [FieldW-1:0] tx_credits [NumPeersDef*Vcs];
  logic [FieldW-1:0] owed_credits [NumPeersDef*Vcs];
  logic [FieldW-1:0] link_pool;
  credit_result_t    result_q [$];

  function automatic logic [FieldW-1:0] sat_sum(logic [FieldW-1:0] a, logic [FieldW-1:0] b);
    logic [FieldW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[FieldW] ? CountMax : s[FieldW-1:0];
  endfunction

  function automatic logic [FieldW-1:0] packet_credits(logic [FieldW-1:0] bytes);
    logic [FieldW:0] per_credit;
    logic [FieldW:0] c;
    if (!regs.size_based_enable) return regs.min_credit;
    per_credit = (regs.bytes_each_credit == 0) ? 1 : {1'b0, regs.bytes_each_credit};
    c = ({1'b0, bytes} + per_credit - 1) / per_credit;
    return (c > regs.min_credit) ? c[FieldW-1:0] : regs.min_credit;
  endfunction

  // apply one beat to the shadow state and return what the block should report
  function automatic credit_result_t apply_credit_op(logic [OpW-1:0] op, logic [PeerW-1:0] peer,
      logic [ChanW-1:0] ch, logic [FieldW-1:0] bytes, logic [FieldW-1:0] amount);
    credit_result_t r;
    logic shared;
    int idx;
    logic [FieldW-1:0] pool;
    logic [FieldW-1:0] total;
    logic [FieldW-1:0] per;
    logic clr;
    int lim;
    r = '0;
    clr = 1'b0;
    shared = !regs.pool_mode && (peer == LinkPeerDef);
    idx = peer * Vcs + ch;
    pool = shared ? link_pool : tx_credits[idx];
    case (op_t'(op))
      OP_CHECK: begin
        r.needed = packet_credits(bytes);
        r.ok = pool >= r.needed;
      end
      OP_CONSUME_SZ, OP_CONSUME_CNT: begin
        r.needed = (op == OP_CONSUME_SZ) ? packet_credits(bytes) : amount;
        if (pool >= r.needed) begin
          pool = pool - r.needed;
          r.ok = 1'b1;
        end
      end
      OP_ADD: begin
        pool = sat_sum(pool, amount);
        r.ok = 1'b1;
      end
      OP_SET: begin
        pool = amount;
        r.ok = 1'b1;
      end
      OP_DATA_RX: begin
        r.needed = packet_credits(bytes);
        if (regs.flow_enable) begin
          owed_credits[idx] = sat_sum(owed_credits[idx], r.needed);
          r.ok = 1'b1;
        end
      end
      OP_RET_POLL: begin
        r.send_credit = regs.flow_enable && (owed_credits[idx] >= regs.return_batch);
        r.ok = r.send_credit;
      end
      OP_CLEAR_OWED: begin
        clr = 1'b1;
        r.ok = 1'b1;
      end
      OP_INIT_PEER: begin
        total = (amount != 0) ? amount : regs.initial_budget;
        per = total / ((regs.vc_count != 0) ? regs.vc_count : 1);
        lim = (regs.vc_count < Vcs) ? regs.vc_count : Vcs;
        if (shared) pool = total;
        for (int v = 0; v < lim; v++) begin
          if (!shared) tx_credits[peer*Vcs+v] = per;
          owed_credits[peer*Vcs+v] = '0;
        end
        // the addressed channel may have just been reloaded
        if (!shared) pool = tx_credits[idx];
        r.ok = 1'b1;
      end
      default: ;
    endcase
    if (shared) link_pool = pool;
    else tx_credits[idx] = pool;
    r.balance = pool;
    r.owed = owed_credits[idx];
    if (clr) owed_credits[idx] = '0;
    return r;
  endfunction

  assign pending = result_q.size();

  always @(posedge clk) begin
    credit_result_t exp_r;
    credit_result_t got;
    if (!rst_n) begin
      regs <= '{flow_enable: 1'b0, pool_mode: 1'b0, vc_count: 4'd4, initial_budget: 16'd20,
                return_batch: 16'd1, size_based_enable: 1'b1, min_credit: 16'd1,
                bytes_each_credit: 16'd256};
      link_pool = '0;
      for (int i = 0; i < NumPeersDef*Vcs; i++) begin
        tx_credits[i] = '0;
        owed_credits[i] = '0;
      end
      result_q.delete();
      fails <= 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_FLOW_EN:  regs.flow_enable <= cfg_data[0];
          CFG_POOL:     regs.pool_mode <= cfg_data[0];
          CFG_VC_COUNT: regs.vc_count <= cfg_data[VcCntW-1:0];
          CFG_INIT_BUD: regs.initial_budget <= cfg_data;
          CFG_RET_BAT:  regs.return_batch <= cfg_data;
          CFG_SIZE_EN:  regs.size_based_enable <= cfg_data[0];
          CFG_MIN_CRED: regs.min_credit <= cfg_data;
          CFG_BPC:      regs.bytes_each_credit <= cfg_data;
          default: ;
        endcase
      end
      // input beat: predict
      if (in_valid && !in_stall)
        result_q.insert(result_q.size(), apply_credit_op(in_operation, in_peer, in_channel,
                                                         in_packet_bytes, in_credit_amount));
      // result beat: compare with oldest expectation
      if (out_valid && !out_stall) begin
        got = '{out_ok, out_needed, out_balance, out_send_credit, out_owed_count};
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result beat ok=%0d needed=%0d balance=%0d send=%0d owed=%0d",
                   $time, got.ok, got.needed, got.balance, got.send_credit, got.owed);
          fails <= fails + 1;
        end else begin
          exp_r = result_q.pop_front();
          if (got.ok !== exp_r.ok)
            $display("%0t: ok expected %0d got %0d", $time, exp_r.ok, got.ok);
          if (got.needed !== exp_r.needed)
            $display("%0t: needed expected %0d got %0d", $time, exp_r.needed, got.needed);
          if (got.balance !== exp_r.balance)
            $display("%0t: balance expected %0d got %0d", $time, exp_r.balance, got.balance);
          if (got.send_credit !== exp_r.send_credit)
            $display("%0t: send_credit expected %0d got %0d", $time, exp_r.send_credit,
                     got.send_credit);
          if (got.owed !== exp_r.owed)
            $display("%0t: owed_count expected %0d got %0d", $time, exp_r.owed, got.owed);
          if (got !== exp_r) fails <= fails + 1;
        end
      end
    end
  end

endmodule

// ===== sim/credit_flow_control_manager_tb.sv =====
module credit_flow_control_manager_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cfcm_pkg::*;

  localparam int StallLimit = 5000;
  localparam int DrainCycles = 25;
  localparam int NumPhases = 8;
  localparam int BeatsPerPhase = 200;
  localparam logic [OpW-1:0] FirstUnusedOp = OP_INIT_PEER + 1;
  localparam logic [OpW-1:0] LastUnusedOp = '1;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [2:0]        cfg_index = '0;
  logic [FieldW-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OpW-1:0]    in_operation = '0;
  logic [PeerW-1:0]  in_peer = '0;
  logic [ChanW-1:0]  in_channel = '0;
  logic [FieldW-1:0] in_packet_bytes = '0;
  logic [FieldW-1:0] in_credit_amount = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_ok;
  logic [FieldW-1:0] out_needed;
  logic [FieldW-1:0] out_balance;
  logic              out_send_credit;
  logic [FieldW-1:0] out_owed_count;
  int                fails;
  int                pending;
  logic              gaps_on = 1'b1;
  int                beats_sent = 0;
  int                idle_cycles = 0;
  int                stall_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  credit_flow_control_manager dut (.*);

  credit_flow_control_manager_chk checker_i (.*);

  // result-side backpressure in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(5, 1) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("credit_flow_control_manager: mismatch");
      $finish;
    end
  end

  task automatic send_beat(logic [OpW-1:0] op, logic [PeerW-1:0] peer, logic [ChanW-1:0] ch,
                           logic [FieldW-1:0] bytes, logic [FieldW-1:0] amount);
    in_valid <= 1'b1;
    in_operation <= op;
    in_peer <= peer;
    in_channel <= ch;
    in_packet_bytes <= bytes;
    in_credit_amount <= amount;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [FieldW-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic send_random_beat();
    logic [OpW-1:0] op;
    logic [FieldW-1:0] bytes;
    logic [FieldW-1:0] amount;
    op = ($urandom_range(0, 19) == 0) ? OpW'($urandom_range(LastUnusedOp, FirstUnusedOp))
                                      : OpW'($urandom_range(OP_INIT_PEER, OP_CHECK));
    bytes = ($urandom_range(0, 3) == 0) ? FieldW'($urandom) : FieldW'($urandom_range(2048, 0));
    amount = ($urandom_range(0, 4) == 0) ? FieldW'($urandom) : FieldW'($urandom_range(64, 0));
    send_beat(op, PeerW'($urandom), ChanW'($urandom), bytes, amount);
  endtask

  initial begin
    logic [VcCntW-1:0] vc_sweep [NumPhases] = '{1, 8, 0, 15, 3, 4, 2, 8};
    logic [FieldW-1:0] bpc_sweep [NumPhases] = '{1, 65535, 0, 256, 64, 3, 1000, 17};
    logic [FieldW-1:0] min_sweep [NumPhases] = '{0, 65535, 1, 2, 0, 1, 3, 0};
    logic [FieldW-1:0] batch_sweep [NumPhases] = '{0, 65535, 1, 8, 3, 100, 0, 5};
    logic [FieldW-1:0] budget_sweep [NumPhases] = '{0, 65535, 20, 64, 1000, 7, 30000, 96};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, flow control still off
    send_beat(OP_INIT_PEER, 0, 2, 0, 0);
    send_beat(OP_CHECK, 0, 5, 0, 0);
    send_beat(OP_CHECK, 0, 1, 16'hFFFF, 0);
    send_beat(OP_CONSUME_SZ, 0, 0, 16'd300, 0);
    send_beat(OP_CONSUME_CNT, 0, 7, 0, 0);
    send_beat(OP_CONSUME_CNT, 0, 7, 0, 16'hFFFF);
    send_beat(OP_ADD, 0, 3, 0, 16'hFFFF);
    send_beat(OP_ADD, 0, 3, 0, 16'd5);
    send_beat(OP_SET, 1, 4, 0, 16'hFFFF);
    send_beat(OP_CONSUME_SZ, 1, 4, 16'hFFFF, 0);
    send_beat(OP_DATA_RX, 1, 4, 16'd1000, 0);
    send_beat(OP_RET_POLL, 1, 4, 0, 0);
    send_beat(OP_CLEAR_OWED, 1, 4, 0, 0);
    send_beat(OP_INIT_PEER, 3, 7, 0, 16'hFFFF);
    send_beat(OP_CONSUME_CNT, 3, 3, 0, 16'h3FFF);
    send_beat(FirstUnusedOp, 2, 6, 16'hFFFF, 16'hFFFF);
    send_beat(LastUnusedOp, 0, 0, 16'h5555, 16'hAAAA);
    drain_results();
    // flow control on: owed accounting, polls and clears
    write_reg(CFG_FLOW_EN, 1);
    write_reg(CFG_RET_BAT, 4);
    cfg_we <= 1'b0;
    send_beat(OP_DATA_RX, 2, 1, 16'd700, 0);
    send_beat(OP_RET_POLL, 2, 1, 0, 0);
    send_beat(OP_DATA_RX, 2, 1, 16'd256, 0);
    send_beat(OP_RET_POLL, 2, 1, 0, 0);
    send_beat(OP_CLEAR_OWED, 2, 1, 0, 0);
    send_beat(OP_RET_POLL, 2, 1, 0, 0);
    drain_results();

    // random phases across register settings
    for (int p = 0; p < NumPhases; p++) begin
      write_reg(CFG_FLOW_EN, (p % 4 != 3));
      write_reg(CFG_POOL, p % 2);
      write_reg(CFG_VC_COUNT, vc_sweep[p]);
      write_reg(CFG_INIT_BUD, budget_sweep[p]);
      write_reg(CFG_RET_BAT, batch_sweep[p]);
      write_reg(CFG_SIZE_EN, (p != 2));
      write_reg(CFG_MIN_CRED, min_sweep[p]);
      write_reg(CFG_BPC, bpc_sweep[p]);
      cfg_we <= 1'b0;
      gaps_on <= (p != 4) && (p < NumPhases - 2);
      // load every peer so consumes see real budgets
      for (int pr = 0; pr < NumPeersDef; pr++) send_beat(OP_INIT_PEER, pr, 0, 0, 0);
      repeat (BeatsPerPhase) send_random_beat();
      drain_results();
    end

    $display("Sent %0d beats over %0d register settings: all operations, both pool modes,",
             beats_sent, NumPhases + 2);
    $display("vc counts 0..15, zero and max credit sizes, saturation and owed returns.");
    if (fails == 0) begin
      $display("credit_flow_control_manager: match");
    end else begin
      $display("credit_flow_control_manager: mismatch");
    end
    $finish;
  end

endmodule

// ===== credit_flow_control_manager.f =====
rtl/cfcm_pkg.sv
rtl/cfcm_divider.sv
rtl/cfcm_front.sv
rtl/cfcm_back.sv
rtl/credit_flow_control_manager.sv
sim/credit_flow_control_manager_chk.sv
sim/credit_flow_control_manager_tb.sv
